[sv/stp_pkg.sv]
// Shared types, constants and helpers for the three-axis trapezoid profile generator.
package stp_pkg;

	localparam int AXES      = 3;
	localparam int FRAC_BITS = 16;
	localparam int DW        = 64;
	localparam int TW        = 32;
	localparam int CAP_W     = 41;

	typedef enum logic [1:0] {
		ACT_TICK   = 2'd0,
		ACT_START  = 2'd1,
		ACT_ORIGIN = 2'd2,
		ACT_NOP    = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		CFG_MAX_SPEED = 3'd0,
		CFG_MAX_ACCEL = 3'd1,
		CFG_TIME_STEP = 3'd2,
		CFG_ORIGIN_X  = 3'd3,
		CFG_ORIGIN_Y  = 3'd4,
		CFG_ORIGIN_Z  = 3'd5
	} cfg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_LEAD,
		ST_VV,
		ST_DA,
		ST_CHOOSE,
		ST_DIV_TP,
		ST_DIV_Q,
		ST_DIV_TJ,
		ST_DIV_N,
		ST_SQRT,
		ST_DEN_A,
		ST_DEN_B,
		ST_DEN_SUM,
		ST_ACC,
		ST_COMMIT,
		ST_TICK,
		ST_TICK_OUT
	} top_state_t;

	typedef enum logic [1:0] {
		LN_IDLE,
		LN_MUL,
		LN_SUM,
		LN_POS
	} lane_state_t;

	typedef struct packed {
		logic          start;
		logic [TW-1:0] t;
		logic [TW-1:0] tp;
		logic [TW-1:0] tj;
	} lane_cmd_t;

	typedef struct packed {
		logic               done;
		logic signed [31:0] pos;
	} lane_res_t;

	function automatic logic [TW-1:0] sat_time(input logic [DW-1:0] v);
		logic [DW-1:0] lim;
		lim = {{(DW-TW){1'b0}}, {TW{1'b1}}};
		return (v > lim) ? {TW{1'b1}} : v[TW-1:0];
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

endpackage

[sv/stp_div.sv]
// Restoring divider, one quotient bit per cycle.
module stp_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [stp_pkg::DW-1:0] dividend,
	input  logic [stp_pkg::DW-1:0] divisor,
	output logic                 done,
	output logic [stp_pkg::DW-1:0] quotient
);
	import stp_pkg::*;

	localparam int CW = $clog2(DW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [DW-1:0] dvs_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          ge;

	always_comb begin
		trial = {rem_q, quo_q[DW-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = (trial >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DW-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[sv/stp_sqrt.sv]
// Integer square root, two radicand bits per cycle.
module stp_sqrt (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [stp_pkg::DW-1:0] radicand,
	output logic                   done,
	output logic [stp_pkg::TW-1:0] root
);
	import stp_pkg::*;

	logic          busy_q;
	logic          done_q;
	logic [DW-1:0] n_q;
	logic [DW-1:0] r_q;
	logic [DW-1:0] bit_q;
	logic [DW-1:0] trial;
	logic          take;

	always_comb begin
		trial = r_q + bit_q;
		take  = (n_q >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= radicand;
			r_q   <= '0;
			bit_q <= DW'(1) << (DW-2);
		end else if (busy_q) begin
			if (take) begin
				n_q <= n_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = r_q[TW-1:0];

endmodule

[sv/stp_lane.sv]
// One axis lane: evaluates the profile position at time t with its own 32x32 multiplier, reused for every product.
module stp_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  stp_pkg::lane_cmd_t  cmd,
	input  logic signed [31:0]  accel,
	input  logic signed [31:0]  base,
	output stp_pkg::lane_res_t  res
);
	import stp_pkg::*;

	localparam logic [DW-1:0] CAP = DW'(1) << (CAP_W-1);

	lane_state_t state_q, state_d;
	logic [1:0]        ph_q;
	logic [1:0]        j_q;
	logic [DW-1:0]     p_q, lo_q, hi_q;
	logic [CAP_W-1:0]  prd_q [3];
	logic [CAP_W:0]    s_q;
	logic signed [31:0] pos_q;

	logic [31:0]   m;
	logic [TW:0]   tptj;
	logic          case1, case2;
	logic [TW-1:0] dt, r;
	logic [31:0]   x_sel, y_sel, mul_a, mul_b;
	logic [DW-1:0] mul_p, prod_sum;
	logic [CAP_W-1:0] prod_cap;
	logic [CAP_W:0]   s_next;
	logic signed [43:0] sum_pos;
	logic signed [31:0] pos_next;

	always_comb begin
		m     = mag32(accel);
		tptj  = {1'b0, cmd.tp} + {1'b0, cmd.tj};
		case1 = (cmd.t <= cmd.tp);
		case2 = !case1 && ({1'b0, cmd.t} < tptj);
		dt    = cmd.t - cmd.tp - cmd.tj;
		r     = (dt < cmd.tp) ? (cmd.tp - dt) : '0;

		unique case (j_q)
			2'd0: begin
				x_sel = cmd.tp;
				y_sel = cmd.tp;
			end
			2'd1: begin
				x_sel = cmd.tp;
				y_sel = case2 ? (cmd.t - cmd.tp) : cmd.tj;
			end
			2'd2: begin
				x_sel = case1 ? cmd.t : r;
				y_sel = case1 ? cmd.t : r;
			end
			default: begin
				x_sel = '0;
				y_sel = '0;
			end
		endcase

		// floor(m*x*y / 2^32) built from three 32x32 products
		unique case (ph_q)
			2'd0: begin
				mul_a = m;
				mul_b = x_sel;
			end
			2'd1: begin
				mul_a = p_q[31:0];
				mul_b = y_sel;
			end
			2'd2: begin
				mul_a = p_q[63:32];
				mul_b = y_sel;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p    = mul_a * mul_b;
		prod_sum = hi_q + {32'd0, lo_q[63:32]};
		prod_cap = (prod_sum > CAP) ? CAP[CAP_W-1:0] : prod_sum[CAP_W-1:0];

		if (case1)
			s_next = {2'b0, prd_q[2][CAP_W-1:1]};
		else if (case2)
			s_next = {2'b0, prd_q[0][CAP_W-1:1]} + {1'b0, prd_q[1]};
		else
			s_next = {1'b0, prd_q[0]} + {1'b0, prd_q[1]} - {2'b0, prd_q[2][CAP_W-1:1]};

		if (accel < 0)
			sum_pos = 44'(base) - $signed({1'b0, s_q});
		else
			sum_pos = 44'(base) + $signed({1'b0, s_q});
		if (sum_pos > 44'sd2147483647)
			pos_next = 32'sh7FFF_FFFF;
		else if (sum_pos < -44'sd2147483648)
			pos_next = 32'sh8000_0000;
		else
			pos_next = sum_pos[31:0];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			LN_IDLE: if (cmd.start) state_d = LN_MUL;
			LN_MUL:  if (ph_q == 2'd3 && j_q == 2'd2) state_d = LN_SUM;
			LN_SUM:  state_d = LN_POS;
			LN_POS:  state_d = LN_IDLE;
			default: state_d = LN_IDLE;
		endcase
	end

	always_comb begin
		res.done = (state_q == LN_POS);
		res.pos  = pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LN_IDLE;
			ph_q    <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == LN_IDLE) begin
				ph_q <= '0;
				j_q  <= '0;
			end else if (state_q == LN_MUL) begin
				ph_q <= ph_q + 1'b1;
				if (ph_q == 2'd3)
					j_q <= j_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == LN_MUL) begin
			unique case (ph_q)
				2'd0: p_q  <= mul_p;
				2'd1: lo_q <= mul_p;
				2'd2: hi_q <= mul_p;
				2'd3: prd_q[j_q] <= prod_cap;
				default: ;
			endcase
		end
		if (state_q == LN_SUM)
			s_q <= s_next;
		if (state_q == LN_POS)
			pos_q <= pos_next;
	end

endmodule

[sv/synced_trapezoid_profile_3axis.sv]
// Top level: move planner, per-axis lanes, merge into the result register.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   action, delta_x, delta_y, delta_z
//   out      output     out_valid/out_stall pos_x, pos_y, pos_z, finished
//   cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// Tick: the time to the result is set by the 12-step multiply sequence of each
//   axis lane (all lanes run together).
// Start: planning time is set by the divider passes (up to five divides) and the
//   square root; a zero-length move skips both.
//   Origin load and the unused action leave the block idle for the next transfer.
// Reset clears all profile state and loads the register defaults; no clearing pass.
// A result waiting under out_stall holds only the next tick at its final merge step.
module synced_trapezoid_profile_3axis (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         action,
	input  logic signed [31:0] delta_x,
	input  logic signed [31:0] delta_y,
	input  logic signed [31:0] delta_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,
	output logic               finished,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import stp_pkg::*;

	localparam int AW = $clog2(AXES);

	// configuration
	logic [30:0]        max_speed_q, max_accel_q;
	logic [15:0]        time_step_q;
	logic signed [31:0] origin_q [3];
	logic [30:0]        v_eff, a_eff;

	top_state_t state_q, state_d;
	logic       launched_q;

	// profile state
	logic [TW-1:0]      elapsed_q, total_q, tp_q, tj_q;
	logic signed [31:0] acc_q [AXES];
	logic signed [31:0] begin_q [AXES];
	logic signed [31:0] cur_q [AXES];

	// planning scratch
	logic signed [31:0] d_q [AXES];
	logic [31:0]        dmag_q [AXES];
	logic [31:0]        dmag_c [AXES];
	logic [AW-1:0]      lead_c, lead_q, acc_idx_q;
	logic [31:0]        dlead_q;
	logic               dzero_q;
	logic [DW-1:0]      vv_q, da_q, n_q, dena_q, denb_q;
	logic [31:0]        q_q;
	logic [48:0]        den_q;
	logic [TW-1:0]      t_q;

	// result register
	logic               out_valid_q, fin_q;
	logic signed [31:0] pos_out_q [3];

	// shared units
	logic [31:0]   mul_a, mul_b;
	logic [DW-1:0] mul_p;
	logic          div_start, div_done;
	logic [DW-1:0] div_dvd, div_dvs, div_quo;
	logic          sq_start, sq_done;
	logic [TW-1:0] sq_root;
	lane_cmd_t     lane_cmd;
	lane_res_t     lane_res [AXES];
	logic          lanes_done;

	logic               in_xfer, out_free, acc_need_div, acc_store, step_clr;
	logic signed [31:0] acc_val;
	logic [30:0]        acc_mag;
	logic [TW:0]        next_t;
	action_t            act;

	assign act   = action_t'(action);
	assign v_eff = (max_speed_q == '0) ? 31'd1 : max_speed_q;
	assign a_eff = (max_accel_q == '0) ? 31'd1 : max_accel_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	always_comb begin
		for (int i = 0; i < AXES; i++)
			dmag_c[i] = mag32(d_q[i]);
		lead_c = '0;
		for (int i = 1; i < AXES; i++)
			if (dmag_c[i] > dmag_c[lead_c])
				lead_c = AW'(i);
	end

	always_comb begin
		lanes_done = 1'b1;
		for (int i = 0; i < AXES; i++)
			lanes_done = lanes_done && lane_res[i].done;
	end

	// acceleration of the axis being planned
	always_comb begin
		acc_need_div = !dzero_q && (acc_idx_q != lead_q) && (den_q != '0);
		acc_store    = !acc_need_div || div_done;
		acc_mag      = (div_quo > DW'(32'h7FFF_FFFF)) ? 31'h7FFF_FFFF : div_quo[30:0];
		if (dzero_q)
			acc_val = '0;
		else if (acc_idx_q == lead_q)
			acc_val = d_q[acc_idx_q][31] ? -$signed({1'b0, a_eff}) : $signed({1'b0, a_eff});
		else if (den_q == '0)
			acc_val = '0;
		else
			acc_val = d_q[acc_idx_q][31] ? -$signed({1'b0, acc_mag}) : $signed({1'b0, acc_mag});
	end

	assign next_t = {1'b0, elapsed_q} + {17'd0, time_step_q};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					unique case (act)
						ACT_TICK:  state_d = ST_TICK;
						ACT_START: state_d = ST_LEAD;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_LEAD:   state_d = ST_VV;
			ST_VV:     state_d = ST_DA;
			ST_DA:     state_d = ST_CHOOSE;
			ST_CHOOSE: begin
				priority if (dzero_q)   state_d = ST_DEN_A;
				else if (vv_q < da_q)   state_d = ST_DIV_TP;
				else                    state_d = ST_DIV_N;
			end
			ST_DIV_TP:  if (div_done) state_d = ST_DIV_Q;
			ST_DIV_Q:   if (div_done) state_d = ST_DIV_TJ;
			ST_DIV_TJ:  if (div_done) state_d = ST_DEN_A;
			ST_DIV_N:   if (div_done) state_d = ST_SQRT;
			ST_SQRT:    if (sq_done) state_d = ST_DEN_A;
			ST_DEN_A:   state_d = ST_DEN_B;
			ST_DEN_B:   state_d = ST_DEN_SUM;
			ST_DEN_SUM: state_d = ST_ACC;
			ST_ACC:     if (acc_store && acc_idx_q == AW'(AXES-1)) state_d = ST_COMMIT;
			ST_COMMIT:  state_d = ST_IDLE;
			ST_TICK:    if (lanes_done) state_d = ST_TICK_OUT;
			ST_TICK_OUT: if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// unit controls
	always_comb begin
		mul_a          = '0;
		mul_b          = '0;
		div_start      = 1'b0;
		div_dvd        = '0;
		div_dvs        = DW'(1);
		sq_start       = 1'b0;
		lane_cmd.start = 1'b0;
		lane_cmd.t     = t_q;
		lane_cmd.tp    = tp_q;
		lane_cmd.tj    = tj_q;
		unique case (state_q)
			ST_VV: begin
				mul_a = {1'b0, v_eff};
				mul_b = {1'b0, v_eff};
			end
			ST_DA: begin
				mul_a = dlead_q;
				mul_b = {1'b0, a_eff};
			end
			ST_DEN_A: begin
				mul_a = tp_q;
				mul_b = tp_q;
			end
			ST_DEN_B: begin
				mul_a = tp_q;
				mul_b = tj_q;
			end
			ST_DIV_TP: begin
				div_start = !launched_q;
				div_dvd   = DW'(v_eff) << FRAC_BITS;
				div_dvs   = DW'(a_eff);
			end
			ST_DIV_Q: begin
				div_start = !launched_q;
				div_dvd   = vv_q;
				div_dvs   = DW'(a_eff);
			end
			ST_DIV_TJ: begin
				div_start = !launched_q;
				div_dvd   = DW'(dlead_q - q_q) << FRAC_BITS;
				div_dvs   = DW'(v_eff);
			end
			ST_DIV_N: begin
				div_start = !launched_q;
				div_dvd   = DW'(dlead_q) << (2*FRAC_BITS);
				div_dvs   = DW'(a_eff);
			end
			ST_SQRT: sq_start = !launched_q;
			ST_ACC: begin
				div_start = acc_need_div && !launched_q;
				div_dvd   = DW'(dmag_q[acc_idx_q]) << FRAC_BITS;
				div_dvs   = DW'(den_q);
			end
			ST_TICK: lane_cmd.start = !launched_q;
			default: ;
		endcase
		mul_p = mul_a * mul_b;
	end

	assign step_clr = (state_d != state_q) || (state_q == ST_ACC && acc_store);

	stp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	stp_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (n_q),
		.done     (sq_done),
		.root     (sq_root)
	);

	for (genvar g = 0; g < AXES; g++) begin : g_lane
		stp_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (lane_cmd),
			.accel  (acc_q[g]),
			.base   (begin_q[g]),
			.res    (lane_res[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q <= 31'd65536;
			max_accel_q <= 31'd65536;
			time_step_q <= 16'd2621;
			for (int i = 0; i < 3; i++)
				origin_q[i] <= '0;
			state_q     <= ST_IDLE;
			launched_q  <= 1'b0;
			out_valid_q <= 1'b0;
			elapsed_q   <= '0;
			total_q     <= '0;
			tp_q        <= '0;
			tj_q        <= '0;
			acc_idx_q   <= '0;
			for (int i = 0; i < AXES; i++) begin
				acc_q[i]   <= '0;
				begin_q[i] <= '0;
				cur_q[i]   <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_MAX_SPEED: max_speed_q <= cfg_data[30:0];
					CFG_MAX_ACCEL: max_accel_q <= cfg_data[30:0];
					CFG_TIME_STEP: time_step_q <= cfg_data[15:0];
					CFG_ORIGIN_X:  origin_q[0] <= cfg_data;
					CFG_ORIGIN_Y:  origin_q[1] <= cfg_data;
					CFG_ORIGIN_Z:  origin_q[2] <= cfg_data;
					default: ;
				endcase
			end

			state_q    <= state_d;
			launched_q <= step_clr ? 1'b0 : (launched_q | div_start | sq_start | lane_cmd.start);

			if (state_q == ST_TICK_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer && act == ACT_ORIGIN)
						for (int i = 0; i < AXES; i++)
							cur_q[i] <= origin_q[i];
				end
				ST_CHOOSE: begin
					if (dzero_q) begin
						tp_q <= '0;
						tj_q <= '0;
					end
				end
				ST_DIV_TP: if (div_done) tp_q <= sat_time(div_quo);
				ST_DIV_TJ: if (div_done) tj_q <= sat_time(div_quo);
				ST_SQRT: begin
					if (sq_done) begin
						tp_q <= sq_root;
						tj_q <= '0;
					end
				end
				ST_DEN_SUM: acc_idx_q <= '0;
				ST_ACC: begin
					if (acc_store) begin
						acc_q[acc_idx_q] <= acc_val;
						acc_idx_q        <= acc_idx_q + 1'b1;
					end
				end
				ST_COMMIT: begin
					for (int i = 0; i < AXES; i++)
						begin_q[i] <= cur_q[i];
					total_q   <= sat_time((DW'(tp_q) << 1) + DW'(tj_q));
					elapsed_q <= '0;
				end
				ST_TICK_OUT: begin
					if (out_free) begin
						for (int i = 0; i < AXES; i++)
							cur_q[i] <= lane_res[i].pos;
						elapsed_q   <= (next_t < {1'b0, total_q}) ? next_t[TW-1:0] : total_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_xfer) begin
			d_q[0] <= delta_x;
			d_q[1] <= delta_y;
			d_q[2] <= delta_z;
			t_q    <= (elapsed_q < total_q) ? elapsed_q : total_q;
		end
		if (state_q == ST_LEAD) begin
			lead_q  <= lead_c;
			dlead_q <= dmag_c[lead_c];
			dzero_q <= (dmag_c[lead_c] == '0);
			for (int i = 0; i < AXES; i++)
				dmag_q[i] <= dmag_c[i];
		end
		if (state_q == ST_VV)
			vv_q <= mul_p;
		if (state_q == ST_DA)
			da_q <= mul_p;
		if (state_q == ST_DIV_Q && div_done)
			q_q <= div_quo[31:0];
		if (state_q == ST_DIV_N && div_done)
			n_q <= div_quo;
		if (state_q == ST_DEN_A)
			dena_q <= mul_p;
		if (state_q == ST_DEN_B)
			denb_q <= mul_p;
		if (state_q == ST_DEN_SUM)
			den_q <= 49'(dena_q >> FRAC_BITS) + 49'(denb_q >> FRAC_BITS);
		if (state_q == ST_TICK_OUT && out_free) begin
			for (int i = 0; i < 3; i++)
				pos_out_q[i] <= lane_res[i].pos;
			fin_q <= (elapsed_q >= total_q);
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x     = pos_out_q[0];
	assign pos_y     = pos_out_q[1];
	assign pos_z     = pos_out_q[2];
	assign finished  = fin_q;

endmodule

[sv/stp_chk.sv]
// Port-level checker for the trapezoid profile generator, bound to the top level.
module stp_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic [1:0]         action,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] pos_x,
	input logic signed [31:0] pos_y,
	input logic signed [31:0] pos_z,
	input logic               finished,
	input logic               cfg_ready
);
	import stp_pkg::*;

	logic in_xfer;
	assign in_xfer = in_valid && !in_stall;

	// a waiting result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pos_x) && $stable(pos_y)
			&& $stable(pos_z) && $stable(finished))
		else $error("result changed while stalled");

	// a move plan occupies the block
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && action == ACT_START |=> in_stall)
		else $error("start transfer did not enter planning");

	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && action == ACT_TICK |=> in_stall)
		else $error("tick transfer did not enter evaluation");

	// origin load and the unused action leave the input unstalled in the next cycle
	a_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && (action == ACT_ORIGIN || action == ACT_NOP) |=> !in_stall)
		else $error("single-cycle action stalled the input");

	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port not ready");

endmodule

bind synced_trapezoid_profile_3axis stp_chk u_stp_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.action    (action),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.pos_x     (pos_x),
	.pos_y     (pos_y),
	.pos_z     (pos_z),
	.finished  (finished),
	.cfg_ready (cfg_ready)
);
